// File: src/tdc_qdc_readout_unpacker_top_assert.svh
// Assertion macros used by the readout unpacker parser RTL.
`ifndef TDC_QDC_READOUT_UNPACKER_TOP_ASSERT_SVH
`define TDC_QDC_READOUT_UNPACKER_TOP_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define TQRU_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define TQRU_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/tqru_pkg.sv
// Package for the readout unpacker: phase codes, hit type and field constants.
package tqru_pkg;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_TIMING = 3'b010,
    PH_CHARGE = 3'b100
  } phase_t;

  localparam int unsigned CountW = 9;
  localparam logic [5:0]  ClockMax = 6'd63;
  localparam logic [11:0] TimeMax  = 12'd4095;

  // One decoded hit
  typedef struct packed {
    logic [3:0]  module_id;
    logic [3:0]  cable_id;
    logic [4:0]  tac_address;
    logic [4:0]  tac_channel;
    logic [3:0]  calibration;
    logic [5:0]  clock_count;
    logic [11:0] tac_time;
    logic [11:0] qdc_charge;
    logic        last_in_block;
  } hit_t;

  // Parser status toward the output stage
  typedef struct packed {
    logic hit_valid;      // accepted word completes a pair
    logic expect_charge;  // next word would produce a hit
  } parse_status_t;

endpackage

// File: src/tqru_parser.sv
// Word parser: header/timing/charge phase tracking and hit field decode.
`include "tdc_qdc_readout_unpacker_top_assert.svh"

module tqru_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_fire,
  input  logic [31:0]           data_word,
  input  logic                  last_of_buffer,
  output tqru_pkg::parse_status_t status,
  output tqru_pkg::hit_t        hit
);

  tqru_pkg::phase_t phase, phase_next;
  logic [tqru_pkg::CountW-1:0] pairs_left, pairs_left_next;
  logic [tqru_pkg::CountW-1:0] pairs_dec;
  logic [tqru_pkg::CountW:0]   pairs_round;
  logic [3:0]  block_module, block_module_next;
  logic [3:0]  block_cable, block_cable_next;
  logic [31:0] held_word;

  assign pairs_dec   = pairs_left - 1'b1;
  assign pairs_round = {1'b0, data_word[tqru_pkg::CountW-1:0]} + 1'b1;

  // Next state for one accepted word
  always_comb begin
    phase_next        = phase;
    pairs_left_next   = pairs_left;
    block_module_next = block_module;
    block_cable_next  = block_cable;
    case (phase)
      tqru_pkg::PH_TIMING: begin
        phase_next = tqru_pkg::PH_CHARGE;
      end
      tqru_pkg::PH_CHARGE: begin
        pairs_left_next = pairs_dec;
        phase_next = (pairs_dec == '0) ? tqru_pkg::PH_HEADER : tqru_pkg::PH_TIMING;
      end
      default: begin
        block_module_next = data_word[31:28];
        block_cable_next  = data_word[27:24];
        // ceil(count / 2)
        pairs_left_next   = pairs_round[tqru_pkg::CountW:1];
        phase_next = (pairs_round[tqru_pkg::CountW:1] == '0) ?
                     tqru_pkg::PH_HEADER : tqru_pkg::PH_TIMING;
      end
    endcase
    // buffer end drops any open block
    if (last_of_buffer) begin
      phase_next      = tqru_pkg::PH_HEADER;
      pairs_left_next = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tqru_pkg::PH_HEADER;
      pairs_left   <= '0;
      block_module <= '0;
      block_cable  <= '0;
    end else if (in_fire) begin
      phase        <= phase_next;
      pairs_left   <= pairs_left_next;
      block_module <= block_module_next;
      block_cable  <= block_cable_next;
    end
  end

  // Held timing word, payload only
  always_ff @(posedge clk) begin
    if (in_fire && phase == tqru_pkg::PH_TIMING) begin
      held_word <= data_word;
    end
  end

  assign status.expect_charge = (phase == tqru_pkg::PH_CHARGE);
  assign status.hit_valid     = in_fire && (phase == tqru_pkg::PH_CHARGE);

  // Hit decode from held timing word and current charge word
  assign hit.module_id     = block_module;
  assign hit.cable_id      = block_cable;
  assign hit.tac_address   = held_word[31:27];
  assign hit.tac_channel   = held_word[26:22];
  assign hit.calibration   = held_word[21:18];
  assign hit.clock_count   = tqru_pkg::ClockMax - held_word[17:12];
  assign hit.tac_time      = tqru_pkg::TimeMax - held_word[11:0];
  assign hit.qdc_charge    = data_word[11:0];
  assign hit.last_in_block = (pairs_dec == '0);

  `TQRU_CHECK(a_phase_onehot, $onehot(phase), "phase not one-hot")
  `TQRU_CHECK(a_header_no_pairs, (phase != tqru_pkg::PH_HEADER) || (pairs_left == '0),
              "pairs left while expecting header")
  `TQRU_CHECK(a_open_block_pairs, (phase == tqru_pkg::PH_HEADER) || (pairs_left != '0),
              "open block with no pairs left")
  `TQRU_NEXT(a_last_hit_closes, status.hit_valid && hit.last_in_block,
             phase == tqru_pkg::PH_HEADER, "last hit did not close block")

endmodule

// File: src/tdc_qdc_readout_unpacker_top.sv
// Top level of the TDC/QDC readout word unpacker.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready  | data_word, last_of_buffer
//  out     | output    | out_valid / out_ready| module_id .. qdc_charge, last_in_block
//
// One word per cycle while in_ready is high; a hit enters the output register in the cycle
// after its charge word. Header and timing words are taken even while a hit waits in the
// output register; a charge word waits only when that register is full and not being drained.
// Reset (rst, synchronous) sets the parser to expect a header and empties the output.
// No clearing pass; the held timing word is written before it is read.

module tdc_qdc_readout_unpacker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] data_word,
  input  logic        last_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  module_id,
  output logic [3:0]  cable_id,
  output logic [4:0]  tac_address,
  output logic [4:0]  tac_channel,
  output logic [3:0]  calibration,
  output logic [5:0]  clock_count,
  output logic [11:0] tac_time,
  output logic [11:0] qdc_charge,
  output logic        last_in_block
);

  tqru_pkg::parse_status_t status;
  tqru_pkg::hit_t          hit;
  tqru_pkg::hit_t          hit_q;
  logic                    in_fire;

  // Only a charge word needs room in the output register
  assign in_ready = !status.expect_charge || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  tqru_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_fire        (in_fire),
    .data_word      (data_word),
    .last_of_buffer (last_of_buffer),
    .status         (status),
    .hit            (hit)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.hit_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (status.hit_valid) begin
      hit_q <= hit;
    end
  end

  assign module_id     = hit_q.module_id;
  assign cable_id      = hit_q.cable_id;
  assign tac_address   = hit_q.tac_address;
  assign tac_channel   = hit_q.tac_channel;
  assign calibration   = hit_q.calibration;
  assign clock_count   = hit_q.clock_count;
  assign tac_time      = hit_q.tac_time;
  assign qdc_charge    = hit_q.qdc_charge;
  assign last_in_block = hit_q.last_in_block;

endmodule
